// ===== hdl/baro_temp_press_compensation_core_macros.svh =====
// Assertion macros shared by the compensation core
`ifndef BARO_TEMP_PRESS_COMPENSATION_CORE_MACROS_SVH
`define BARO_TEMP_PRESS_COMPENSATION_CORE_MACROS_SVH

// same-cycle implication
`define BTPC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("btpc assertion failed");

// next-cycle implication
`define BTPC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("btpc assertion failed");

`endif

// ===== hdl/btpc_pkg.sv =====
// Types, constants and arithmetic helpers for the compensation core
package btpc_pkg;

    localparam int unsigned DIV_STEPS = 64;

    localparam logic [2:0] CFG_TEMP_COEF_1        = 3'd0;
    localparam logic [2:0] CFG_TEMP_COEF_2        = 3'd1;
    localparam logic [2:0] CFG_TEMP_COEF_3        = 3'd2;
    localparam logic [2:0] CFG_PRESS_COEF_1       = 3'd3;
    localparam logic [2:0] CFG_PRESS_COEFS_2_TO_5 = 3'd4;
    localparam logic [2:0] CFG_PRESS_COEFS_6_TO_9 = 3'd5;

    localparam logic signed [33:0] TEMP_OFFSET = 34'sd128000;
    localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
    localparam logic [11:0]        PRESS_SCALE = 12'd3125;
    localparam logic [31:0]        ROUND_HALF  = 32'd128;
    localparam logic [31:0]        TEMP_MUL    = 32'd5;
    localparam logic [63:0]        PRESS_BIAS  = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] temp;
        logic signed [31:0] tfine;
        logic signed [33:0] x;
        logic        [19:0] adc_p;
    } temp_res_t;

    typedef struct packed {
        logic signed [31:0] temp;
        logic signed [31:0] tfine;
        logic        [63:0] num;
        logic        [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic signed [31:0] temp;
        logic signed [31:0] tfine;
        logic        [63:0] quo;
        logic               inv;
    } div_res_t;

    function automatic logic [48:0] mul_lo_s(input logic [31:0] a, input logic signed [15:0] c);
        logic signed [48:0] ae;
        logic signed [48:0] ce;
        ae = $signed({17'd0, a});
        ce = 49'(c);
        return ae * ce;
    endfunction

    function automatic logic [31:0] mul_hi_s(input logic [31:0] a, input logic signed [15:0] c);
        return a * {{16{c[15]}}, c};
    endfunction

    function automatic logic [63:0] sext49(input logic [48:0] v);
        return {{15{v[48]}}, v};
    endfunction

endpackage

// ===== hdl/btpc_if.sv =====
// Channel interfaces: measurement in, result out, coefficient writes
interface btpc_meas_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface btpc_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic        [31:0] pressure_q24_8;
    logic               pressure_invalid;
    modport source (output valid, output temperature_centi, output fine_temperature,
                    output pressure_q24_8, output pressure_invalid, input ready);
    modport sink (input valid, input temperature_centi, input fine_temperature,
                  input pressure_q24_8, input pressure_invalid, output ready);
endinterface

interface btpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/btpc_temp.sv =====
// Temperature pipeline: fine temperature and hundredths of a degree
module btpc_temp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [19:0]           raw_temperature,
    input  logic [19:0]           raw_pressure,
    input  btpc_pkg::cfg_t        coef,
    output logic                  out_valid,
    output btpc_pkg::temp_res_t   out_data
);
    import btpc_pkg::*;

    localparam int STAGES = 4;

    logic [STAGES-1:0]  vld_reg;
    logic signed [18:0] a_w;
    logic signed [17:0] b_w;
    logic signed [34:0] m1_next;
    logic signed [35:0] m2_next;
    logic [31:0]        m1_reg;
    logic [31:0]        m2_reg;
    logic [19:0]        p1_reg;
    logic [19:0]        p2_reg;
    logic [19:0]        p3_reg;
    logic signed [31:0] tv1_next;
    logic signed [31:0] tv1_reg;
    logic signed [19:0] s_w;
    logic signed [35:0] m3_next;
    logic [31:0]        m3_reg;
    logic signed [31:0] tv2_w;
    logic signed [31:0] tfine_next;
    logic signed [31:0] tfine_reg;
    logic [31:0]        t5_w;
    temp_res_t          out_next;
    temp_res_t          out_reg;

    always_comb
    begin
        a_w        = $signed({2'b00, raw_temperature[19:3]}) - $signed({2'b00, coef.t1, 1'b0});
        b_w        = $signed({2'b00, raw_temperature[19:4]}) - $signed({2'b00, coef.t1});
        m1_next    = a_w * coef.t2;
        m2_next    = b_w * b_w;
        tv1_next   = $signed(m1_reg) >>> 11;
        s_w        = 20'($signed(m2_reg) >>> 12);
        m3_next    = s_w * coef.t3;
        tv2_w      = $signed(m3_reg) >>> 14;
        tfine_next = tv1_reg + tv2_w;
        t5_w       = tfine_reg * TEMP_MUL + ROUND_HALF;
        out_next.temp  = $signed(t5_w) >>> 8;
        out_next.tfine = tfine_reg;
        out_next.x     = $signed({{2{tfine_reg[31]}}, tfine_reg}) - TEMP_OFFSET;
        out_next.adc_p = p3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg    <= m1_next[31:0];
            m2_reg    <= m2_next[31:0];
            p1_reg    <= raw_pressure;
            tv1_reg   <= tv1_next;
            m3_reg    <= m3_next[31:0];
            p2_reg    <= p1_reg;
            tfine_reg <= tfine_next;
            p3_reg    <= p2_reg;
            out_reg   <= out_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_data  = out_reg;

endmodule

// ===== hdl/btpc_pre.sv =====
// Pressure pipeline up to the divider: dividend and divisor in 64 bits
module btpc_pre (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  btpc_pkg::temp_res_t   in_data,
    input  btpc_pkg::cfg_t        coef,
    output logic                  out_valid,
    output btpc_pkg::div_req_t    out_data
);
    import btpc_pkg::*;

    localparam int STAGES = 7;

    logic [STAGES-1:0]  vld_reg;
    temp_res_t          ctx_reg [STAGES-1];
    logic signed [67:0] sq_w;
    logic signed [49:0] m5_w;
    logic signed [49:0] m2_w;
    logic [62:0]        sq_reg;
    logic [49:0]        m5a_reg;
    logic [49:0]        m2a_reg;
    logic [48:0]        pp6lo_reg;
    logic [31:0]        pp6hi_reg;
    logic [48:0]        pp3lo_reg;
    logic [31:0]        pp3hi_reg;
    logic [49:0]        m5b_reg;
    logic [49:0]        m2b_reg;
    logic [63:0]        prod6_reg;
    logic [63:0]        prod3_reg;
    logic [49:0]        m5c_reg;
    logic [49:0]        m2c_reg;
    logic [63:0]        v2_next;
    logic [63:0]        v1a_next;
    logic [63:0]        v2_reg;
    logic [63:0]        v1a_reg;
    logic [20:0]        pf_w;
    logic [63:0]        y_reg;
    logic [63:0]        nb_reg;
    logic [47:0]        yl_next;
    logic [31:0]        yh_next;
    logic [43:0]        nl_next;
    logic [31:0]        nh_next;
    logic [47:0]        yl_reg;
    logic [31:0]        yh_reg;
    logic [43:0]        nl_reg;
    logic [31:0]        nh_reg;
    logic [63:0]        prody_w;
    div_req_t           out_next;
    div_req_t           out_reg;

    always_comb
    begin
        sq_w     = in_data.x * in_data.x;
        m5_w     = in_data.x * coef.p5;
        m2_w     = in_data.x * coef.p2;
        v2_next  = prod6_reg + ({{14{m5c_reg[49]}}, m5c_reg} << 17)
                   + ({{48{coef.p4[15]}}, coef.p4} << 35);
        v1a_next = {{8{prod3_reg[63]}}, prod3_reg[63:8]}
                   + ({{14{m2c_reg[49]}}, m2c_reg} << 12);
        pf_w     = PRESS_FULL - {1'b0, ctx_reg[3].adc_p};
        yl_next  = y_reg[31:0] * coef.p1;
        yh_next  = y_reg[63:32] * {16'd0, coef.p1};
        nl_next  = nb_reg[31:0] * PRESS_SCALE;
        nh_next  = nb_reg[63:32] * {20'd0, PRESS_SCALE};
        prody_w  = {16'd0, yl_reg} + {yh_reg, 32'd0};
        out_next.temp  = ctx_reg[5].temp;
        out_next.tfine = ctx_reg[5].tfine;
        out_next.den   = $signed(prody_w) >>> 33;
        out_next.num   = {20'd0, nl_reg} + {nh_reg, 32'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_data;
            for (int k = 1; k < STAGES - 1; k++)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
            sq_reg    <= sq_w[62:0];
            m5a_reg   <= m5_w;
            m2a_reg   <= m2_w;
            pp6lo_reg <= mul_lo_s(sq_reg[31:0], coef.p6);
            pp6hi_reg <= mul_hi_s({1'b0, sq_reg[62:32]}, coef.p6);
            pp3lo_reg <= mul_lo_s(sq_reg[31:0], coef.p3);
            pp3hi_reg <= mul_hi_s({1'b0, sq_reg[62:32]}, coef.p3);
            m5b_reg   <= m5a_reg;
            m2b_reg   <= m2a_reg;
            prod6_reg <= sext49(pp6lo_reg) + {pp6hi_reg, 32'd0};
            prod3_reg <= sext49(pp3lo_reg) + {pp3hi_reg, 32'd0};
            m5c_reg   <= m5b_reg;
            m2c_reg   <= m2b_reg;
            v2_reg    <= v2_next;
            v1a_reg   <= v1a_next;
            y_reg     <= PRESS_BIAS + v1a_reg;
            nb_reg    <= ({43'd0, pf_w} << 31) - v2_reg;
            yl_reg    <= yl_next;
            yh_reg    <= yh_next;
            nl_reg    <= nl_next;
            nh_reg    <= nh_next;
            out_reg   <= out_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_data  = out_reg;

endmodule

// ===== hdl/btpc_div.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage
`include "baro_temp_press_compensation_core_macros.svh"
module btpc_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  btpc_pkg::div_req_t    in_data,
    output logic                  out_valid,
    output btpc_pkg::div_res_t    out_data
);
    import btpc_pkg::*;

    logic [DIV_STEPS+1:0] vld_reg;
    logic [63:0]          r_reg     [DIV_STEPS+1];
    logic [63:0]          n_reg     [DIV_STEPS+1];
    logic [63:0]          d_reg     [DIV_STEPS+1];
    logic [DIV_STEPS:0]   sgn_reg;
    logic [DIV_STEPS:0]   inv_reg;
    logic signed [31:0]   temp_reg  [DIV_STEPS+1];
    logic signed [31:0]   tfine_reg [DIV_STEPS+1];
    logic [64:0]          rs_w      [DIV_STEPS];
    logic [65:0]          df_w      [DIV_STEPS];
    logic [63:0]          rn_w      [DIV_STEPS];
    logic [63:0]          nmag_w;
    logic [63:0]          dmag_w;
    div_res_t             out_next;
    div_res_t             out_reg;

    always_comb
    begin
        nmag_w = in_data.num[63] ? (64'd0 - in_data.num) : in_data.num;
        dmag_w = in_data.den[63] ? (64'd0 - in_data.den) : in_data.den;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            rs_w[j] = {r_reg[j], n_reg[j][63]};
            df_w[j] = {1'b0, rs_w[j]} - {2'b00, d_reg[j]};
            rn_w[j] = df_w[j][65] ? rs_w[j][63:0] : df_w[j][63:0];
        end
        out_next.temp  = temp_reg[DIV_STEPS];
        out_next.tfine = tfine_reg[DIV_STEPS];
        out_next.quo   = sgn_reg[DIV_STEPS] ? (64'd0 - n_reg[DIV_STEPS]) : n_reg[DIV_STEPS];
        out_next.inv   = inv_reg[DIV_STEPS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STEPS:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]     <= 64'd0;
            n_reg[0]     <= nmag_w;
            d_reg[0]     <= dmag_w;
            sgn_reg[0]   <= in_data.num[63] ^ in_data.den[63];
            inv_reg[0]   <= (in_data.den == 64'd0);
            temp_reg[0]  <= in_data.temp;
            tfine_reg[0] <= in_data.tfine;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                r_reg[k]     <= rn_w[k-1];
                n_reg[k]     <= {n_reg[k-1][62:0], !df_w[k-1][65]};
                d_reg[k]     <= d_reg[k-1];
                sgn_reg[k]   <= sgn_reg[k-1];
                inv_reg[k]   <= inv_reg[k-1];
                temp_reg[k]  <= temp_reg[k-1];
                tfine_reg[k] <= tfine_reg[k-1];
            end
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[DIV_STEPS+1];
    assign out_data  = out_reg;

    `BTPC_ASSERT_IMP(a_rem_below_div, clk, rst_n, vld_reg[DIV_STEPS] && !inv_reg[DIV_STEPS], r_reg[DIV_STEPS] < d_reg[DIV_STEPS])

endmodule

// ===== hdl/btpc_post.sv =====
// Pressure pipeline after the divider and the output register
`include "baro_temp_press_compensation_core_macros.svh"
module btpc_post (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  btpc_pkg::div_res_t    in_data,
    input  btpc_pkg::cfg_t        coef,
    output logic                  out_valid,
    output logic signed [31:0]    temperature_centi,
    output logic signed [31:0]    fine_temperature,
    output logic [31:0]           pressure_q24_8,
    output logic                  pressure_invalid
);
    import btpc_pkg::*;

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg;
    div_res_t          ctx_reg [STAGES];
    logic [63:0]       q_w;
    logic [63:0]       q1_reg;
    logic [48:0]       pp9lo_reg;
    logic [31:0]       pp9hi_reg;
    logic [48:0]       pp8lo_reg;
    logic [31:0]       pp8hi_reg;
    logic [63:0]       p8sum_w;
    logic [63:0]       q2_reg;
    logic [63:0]       w_reg;
    logic [63:0]       v2a_reg;
    logic [63:0]       wlql_reg;
    logic [31:0]       wlqh_reg;
    logic [31:0]       whql_reg;
    logic [63:0]       v2b_reg;
    logic [63:0]       v1sum_w;
    logic [63:0]       v1_reg;
    logic [63:0]       v2c_reg;
    logic [63:0]       s_reg;
    logic [63:0]       pr_w;
    logic [31:0]       press_next;
    logic [31:0]       press_reg;

    always_comb
    begin
        q_w        = $signed(in_data.quo) >>> 13;
        p8sum_w    = sext49(pp8lo_reg) + {pp8hi_reg, 32'd0};
        v1sum_w    = wlql_reg + {wlqh_reg + whql_reg, 32'd0};
        pr_w       = {{8{s_reg[63]}}, s_reg[63:8]} + ({{48{coef.p7[15]}}, coef.p7} << 4);
        press_next = ctx_reg[4].inv ? 32'd0 : pr_w[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_data;
            for (int k = 1; k < STAGES; k++)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
            q1_reg    <= q_w;
            pp9lo_reg <= mul_lo_s(q_w[31:0], coef.p9);
            pp9hi_reg <= mul_hi_s(q_w[63:32], coef.p9);
            pp8lo_reg <= mul_lo_s(in_data.quo[31:0], coef.p8);
            pp8hi_reg <= mul_hi_s(in_data.quo[63:32], coef.p8);
            q2_reg    <= q1_reg;
            w_reg     <= sext49(pp9lo_reg) + {pp9hi_reg, 32'd0};
            v2a_reg   <= $signed(p8sum_w) >>> 19;
            wlql_reg  <= w_reg[31:0] * q2_reg[31:0];
            wlqh_reg  <= w_reg[31:0] * q2_reg[63:32];
            whql_reg  <= w_reg[63:32] * q2_reg[31:0];
            v2b_reg   <= v2a_reg;
            v1_reg    <= $signed(v1sum_w) >>> 25;
            v2c_reg   <= v2b_reg;
            s_reg     <= ctx_reg[3].quo + v1_reg + v2c_reg;
            press_reg <= press_next;
        end
    end

    assign out_valid         = vld_reg[STAGES-1];
    assign temperature_centi = ctx_reg[STAGES-1].temp;
    assign fine_temperature  = ctx_reg[STAGES-1].tfine;
    assign pressure_invalid  = ctx_reg[STAGES-1].inv;
    assign pressure_q24_8    = press_reg;

    `BTPC_ASSERT_IMP(a_inv_forces_zero, clk, rst_n,
                     vld_reg[STAGES-1] && ctx_reg[STAGES-1].inv, press_reg == 32'd0)
    `BTPC_ASSERT_NXT(a_hold_on_stall, clk, rst_n,
                     vld_reg[STAGES-1] && !en, vld_reg[STAGES-1] && $stable(press_reg))

endmodule

// ===== hdl/baro_temp_press_compensation_core.sv =====
// Top level: coefficient registers and the compensation pipeline
// Throughput: one beat per cycle; a single shared enable advances all stages
// and holds them while a result beat waits on res.ready.
// Reset clears all stage valid bits and sets every coefficient register to zero.
module baro_temp_press_compensation_core (
    input  logic    clk,
    input  logic    rst_n,
    btpc_meas_if.sink   meas,
    btpc_res_if.source  res,
    btpc_cfg_if.sink    cfg
);
    import btpc_pkg::*;

    cfg_t       coef_reg;
    logic       en;
    logic       temp_valid;
    temp_res_t  temp_data;
    logic       pre_valid;
    div_req_t   pre_data;
    logic       div_valid;
    div_res_t   div_data;
    logic       post_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TEMP_COEF_1:  coef_reg.t1 <= cfg.data[15:0];
                CFG_TEMP_COEF_2:  coef_reg.t2 <= cfg.data[15:0];
                CFG_TEMP_COEF_3:  coef_reg.t3 <= cfg.data[15:0];
                CFG_PRESS_COEF_1: coef_reg.p1 <= cfg.data[15:0];
                CFG_PRESS_COEFS_2_TO_5:
                begin
                    coef_reg.p2 <= cfg.data[15:0];
                    coef_reg.p3 <= cfg.data[31:16];
                    coef_reg.p4 <= cfg.data[47:32];
                    coef_reg.p5 <= cfg.data[63:48];
                end
                CFG_PRESS_COEFS_6_TO_9:
                begin
                    coef_reg.p6 <= cfg.data[15:0];
                    coef_reg.p7 <= cfg.data[31:16];
                    coef_reg.p8 <= cfg.data[47:32];
                    coef_reg.p9 <= cfg.data[63:48];
                end
                default: ;
            endcase
        end
    end

    assign cfg.ready  = 1'b1;
    assign en         = !post_valid || res.ready;
    assign meas.ready = en;
    assign res.valid  = post_valid;

    btpc_temp u_temp (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (meas.valid),
        .raw_temperature (meas.raw_temperature),
        .raw_pressure    (meas.raw_pressure),
        .coef            (coef_reg),
        .out_valid       (temp_valid),
        .out_data        (temp_data)
    );

    btpc_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (temp_valid),
        .in_data   (temp_data),
        .coef      (coef_reg),
        .out_valid (pre_valid),
        .out_data  (pre_data)
    );

    btpc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_valid),
        .in_data   (pre_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    btpc_post u_post (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_valid          (div_valid),
        .in_data           (div_data),
        .coef              (coef_reg),
        .out_valid         (post_valid),
        .temperature_centi (res.temperature_centi),
        .fine_temperature  (res.fine_temperature),
        .pressure_q24_8    (res.pressure_q24_8),
        .pressure_invalid  (res.pressure_invalid)
    );

endmodule

// ===== tb/sv/btpc_checker.sv =====
// Checker: watches the channels, predicts each measurement's result and compares
module btpc_checker (
    input  logic  clk,
    input  logic  rst_n,
    btpc_meas_if  meas,
    btpc_res_if   res,
    btpc_cfg_if   cfg,
    output int    errors,
    output int    pending
);
    import btpc_pkg::*;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] tfine;
        logic [31:0] press;
        logic        inv;
    } comp_t;

    cfg_t  coefs;
    comp_t expected_q[$];

    function automatic logic [31:0] asr32(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic comp_t compensate(cfg_t c, logic [19:0] rt, logic [19:0] rp);
        logic [31:0] t1, t2, t3, a, b, m, tfine;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, p, q, num;
        comp_t r;
        t1 = {16'd0, c.t1};
        t2 = 32'(c.t2);
        t3 = 32'(c.t3);
        p1 = {48'd0, c.p1};
        p2 = 64'(c.p2);
        p3 = 64'(c.p3);
        p4 = 64'(c.p4);
        p5 = 64'(c.p5);
        p6 = 64'(c.p6);
        p7 = 64'(c.p7);
        p8 = 64'(c.p8);
        p9 = 64'(c.p9);
        a = 32'(rt >> 3) - (t1 << 1);
        m = a * t2;
        tfine = asr32(m, 11);
        b = 32'(rt >> 4) - t1;
        m = b * b;
        m = asr32(m, 12) * t3;
        tfine = tfine + asr32(m, 14);
        m = tfine * 32'd5 + 32'd128;
        r.temp = asr32(m, 8);
        r.tfine = tfine;
        v1 = 64'($signed(tfine)) - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
        r.press = '0;
        r.inv = 1'b0;
        if (v1 == 64'd0)
        begin
            r.inv = 1'b1;
        end
        else
        begin
            p = 64'd1048576 - 64'(rp);
            num = ((p << 31) - v2) * 64'd3125;
            if (v1 == '1)
            begin
                p = 64'd0 - num;
            end
            else
            begin
                p = $signed(num) / $signed(v1);
            end
            q = asr64(p, 13);
            v1 = asr64(p9 * q * q, 25);
            v2 = asr64(p8 * p, 19);
            r.press = 32'(asr64(p + v1 + v2, 8) + (p7 << 4));
        end
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        comp_t e;
        int    n_err;
        if (!rst_n)
        begin
            coefs <= '0;
            errors <= 0;
            expected_q.delete();
        end
        else
        begin
            n_err = 0;
            if (meas.valid && meas.ready)
                expected_q.push_back(compensate(coefs, meas.raw_temperature, meas.raw_pressure));
            if (res.valid && res.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    n_err = n_err + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (res.temperature_centi !== e.temp)
                    begin
                        $error("temperature_centi expected %0d got %0d",
                               $signed(e.temp), res.temperature_centi);
                        n_err = n_err + 1;
                    end
                    if (res.fine_temperature !== e.tfine)
                    begin
                        $error("fine_temperature expected %0d got %0d",
                               $signed(e.tfine), res.fine_temperature);
                        n_err = n_err + 1;
                    end
                    if (res.pressure_q24_8 !== e.press)
                    begin
                        $error("pressure_q24_8 expected %0d got %0d", e.press, res.pressure_q24_8);
                        n_err = n_err + 1;
                    end
                    if (res.pressure_invalid !== e.inv)
                    begin
                        $error("pressure_invalid expected %0d got %0d",
                               e.inv, res.pressure_invalid);
                        n_err = n_err + 1;
                    end
                end
            end
            errors <= errors + n_err;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_TEMP_COEF_1:        coefs.t1 <= cfg.data[15:0];
                    CFG_TEMP_COEF_2:        coefs.t2 <= cfg.data[15:0];
                    CFG_TEMP_COEF_3:        coefs.t3 <= cfg.data[15:0];
                    CFG_PRESS_COEF_1:       coefs.p1 <= cfg.data[15:0];
                    CFG_PRESS_COEFS_2_TO_5: {coefs.p5, coefs.p4, coefs.p3, coefs.p2} <= cfg.data;
                    CFG_PRESS_COEFS_6_TO_9: {coefs.p9, coefs.p8, coefs.p7, coefs.p6} <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: clock, reset, stimulus, coefficient phases and verdict
module tb_top;
    import btpc_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off;
    bit   hold_done;
    int   quiet_cycles;

    btpc_meas_if meas();
    btpc_res_if  res();
    btpc_cfg_if  cfg();

    baro_temp_press_compensation_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .meas  (meas),
        .res   (res),
        .cfg   (cfg)
    );

    btpc_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .meas    (meas),
        .res     (res),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_meas(logic [19:0] rt, logic [19:0] rp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            meas.valid <= 1'b0;
            @(posedge clk);
        end
        meas.valid <= 1'b1;
        meas.raw_temperature <= rt;
        meas.raw_pressure <= rp;
        do @(posedge clk); while (!meas.ready);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        meas.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic load_coefs(logic [15:0] t1, t2, t3, p1, logic [63:0] p25, p69);
        write_reg(CFG_TEMP_COEF_1, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000 | t1);
        write_reg(CFG_TEMP_COEF_2, {48'd0, t2});
        write_reg(CFG_TEMP_COEF_3, {48'd0, t3});
        write_reg(CFG_PRESS_COEF_1, {48'd0, p1});
        write_reg(CFG_PRESS_COEFS_2_TO_5, p25);
        write_reg(CFG_PRESS_COEFS_6_TO_9, p69);
    endtask

    task automatic load_typical();
        load_coefs(16'd27504, 16'd26435, -16'sd1000, 16'd36477,
                   {16'd140, 16'd2855, 16'd3024, -16'sd10685},
                   {16'd6000, -16'sd14600, 16'd15500, -16'sd7});
    endtask

    function automatic logic [19:0] rand_raw(int lo, int hi);
        if ($urandom_range(1))
            return 20'($urandom_range(hi, lo));
        return 20'($urandom_range(20'hFFFFF));
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
        end
        else if (hold_off && !hold_done)
        begin
            res.ready <= 1'b0;
            repeat (400) @(posedge clk);
            hold_done = 1'b1;
        end
        else
        begin
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((meas.valid && meas.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("baro_temp_press_compensation_core test failed");
            $finish;
        end
    end

    initial
    begin
        logic [19:0] edge_vals[5];
        int modes[4][2];
        edge_vals = '{20'd0, 20'hFFFFF, 20'h80000, 20'd519888, 20'd415148};
        modes = '{'{0, 0}, '{75, 0}, '{0, 75}, '{34, 34}};
        rst_n = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        meas.valid = 1'b0;
        meas.raw_temperature = '0;
        meas.raw_pressure = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero coefficients: divisor is zero
        for (int i = 0; i < 3; i++)
            send_meas(edge_vals[i], edge_vals[4 - i]);
        load_typical();
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 3; j++)
                send_meas(edge_vals[i], edge_vals[j + 2]);
        load_coefs(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, {4{16'h7FFF}}, {4{16'h7FFF}});
        send_meas(20'd0, 20'd0);
        send_meas(20'hFFFFF, 20'hFFFFF);
        load_coefs(16'd0, 16'h8000, 16'h8000, 16'd0, {4{16'h8000}}, {4{16'h8000}});
        send_meas(20'd0, 20'hFFFFF);
        send_meas(20'hFFFFF, 20'd0);

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph % 3)
                0: load_typical();
                1: load_coefs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              {$urandom, $urandom}, {$urandom, $urandom});
                default: load_coefs(16'($urandom_range(20000, 40000)),
                                    16'($urandom_range(20000, 30000)),
                                    -16'sd1000, 16'($urandom_range(30000, 40000)),
                                    {16'd140, 16'd2855, 16'd3024, -16'sd10685},
                                    {$urandom, $urandom});
            endcase
            send_idle_pct = modes[ph % 4][0];
            recv_stall_pct = modes[ph % 4][1];
            if (ph == 4)
                hold_off = 1'b1;
            for (int k = 0; k < 85; k++)
                send_meas(rand_raw(400000, 600000), rand_raw(250000, 450000));
        end
        meas.valid <= 1'b0;
        recv_stall_pct = 0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("baro_temp_press_compensation_core test passed");
        else
            $display("baro_temp_press_compensation_core test failed");
        $finish;
    end

endmodule
